// File: design/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants of the byte stream reassembler
// Field widths of the input and result channels and the command codes.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int IDX_W   = 64;
  localparam int BYTE_W  = 8;
  localparam int AVAIL_W = 13;
  localparam int PEND_W  = 13;
  localparam int CMD_W   = 2;

  // Code 3 carries no meaning and is handled as a no-op.
  typedef enum logic [CMD_W-1:0] {
    CMD_DATA  = 2'd0,
    CMD_END   = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_t;

endpackage

// File: design/bsr_if.sv
// ----------------------------------------------------------------------------
// bsr_in_if / bsr_out_if: valid/ready channels of the reassembler
// One interface for the item stream in and one for the result stream out.
// ----------------------------------------------------------------------------
interface bsr_in_if;
  import bsr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [IDX_W-1:0]     stream_index;
  logic [BYTE_W-1:0]    data_byte;
  logic                 is_final_byte;
  logic [AVAIL_W-1:0]   avail_capacity;

  modport source (output valid, cmd, stream_index, data_byte, is_final_byte,
                  avail_capacity, input ready);
  modport sink   (input valid, cmd, stream_index, data_byte, is_final_byte,
                  avail_capacity, output ready);
endinterface

interface bsr_out_if;
  import bsr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 out_valid;
  logic [BYTE_W-1:0]    out_byte;
  logic [IDX_W-1:0]     next_index;
  logic [PEND_W-1:0]    pending_count;
  logic                 stream_closed;

  modport source (output valid, out_valid, out_byte, next_index, pending_count,
                  stream_closed, input ready);
  modport sink   (input valid, out_valid, out_byte, next_index, pending_count,
                  stream_closed, output ready);
endinterface

// File: design/bsr_window.sv
// ----------------------------------------------------------------------------
// bsr_window: receive window check and ring slot of one stream index
// Tests an index against [base, base + avail), avail capped at CAPACITY, and maps it to its slot.
// ----------------------------------------------------------------------------
module bsr_window #(
  parameter int CAPACITY = 4096
) (
  input  logic [bsr_pkg::IDX_W-1:0]     base_idx,
  input  logic [$clog2(CAPACITY)-1:0]   base_slot,
  input  logic [bsr_pkg::IDX_W-1:0]     idx,
  input  logic [bsr_pkg::AVAIL_W-1:0]   avail,
  output logic                          hit,
  output logic [$clog2(CAPACITY)-1:0]   slot
);
  import bsr_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CW > AVAIL_W) ? CW : AVAIL_W;

  logic [AW-1:0]    avail_ext;
  logic [AW-1:0]    avail_sat;
  logic [IDX_W-1:0] diff;
  logic [SW:0]      slot_sum;

  assign avail_ext = AW'(avail);
  assign avail_sat = (avail_ext > AW'(CAPACITY)) ? AW'(CAPACITY) : avail_ext;
  assign diff      = idx - base_idx;
  assign hit       = (idx >= base_idx) && (diff < IDX_W'(avail_sat));

  // Offset is below CAPACITY on a hit, so one conditional subtract wraps it.
  assign slot_sum  = (SW+1)'(base_slot) + {1'b0, diff[SW-1:0]};
  assign slot      = (slot_sum >= (SW+1)'(CAPACITY)) ?
                     SW'(slot_sum - (SW+1)'(CAPACITY)) : slot_sum[SW-1:0];

endmodule

// File: design/byte_stream_reassembler_core.sv
// ----------------------------------------------------------------------------
// byte_stream_reassembler_core: out-of-order byte stream reassembler
// Stores bytes by absolute index in a ring with valid marks, drains them in
// stream order and tracks the stream end and closing.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake          payload
//  in_chan    in   valid/ready        cmd, stream_index, data_byte,
//                                     is_final_byte, avail_capacity
//  out_chan   out  valid/ready        out_valid, out_byte, next_index,
//                                     pending_count, stream_closed
//
// One item per cycle is taken while no held result stalls the decide stage;
// its result passes the ring read register, then the result register. The
// ring has one write port and one registered read port; a write in the
// decide stage is forwarded to a read of the same slot issued in that cycle.
// After reset a clearing pass zeroes the valid marks, one slot at a time;
// in_chan.ready stays low for its duration.
// A held result stalls the decide stage, and in_chan.ready then follows
// out_chan.ready.
// ----------------------------------------------------------------------------
module byte_stream_reassembler_core #(
  parameter int CAPACITY = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  bsr_in_if.sink     in_chan,
  bsr_out_if.source  out_chan
);
  import bsr_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > PEND_W) ? CW : PEND_W;

  // Ring: valid mark on top of the byte.
  logic [BYTE_W:0]    ring_mem [CAPACITY];
  logic [BYTE_W:0]    rd_word_r;

  // Decide stage registers.
  logic               s1_v_r;
  logic [CMD_W-1:0]   s1_cmd_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic               s1_fin_r;
  logic               s1_hit_r;
  logic [SW-1:0]      s1_slot_r;
  logic               fwd_v_r;
  logic [BYTE_W:0]    fwd_word_r;

  // Stream state.
  logic [IDX_W-1:0]   ne_r, ne_nxt, ne_plus;
  logic [SW-1:0]      hs_r, hs_nxt, hs_plus;
  logic [IDX_W-1:0]   end_pos_r, end_pos_nxt;
  logic               end_known_r, end_known_nxt;
  logic [PW-1:0]      pend_r, pend_nxt;
  logic               closed_r, closed_nxt;

  // Result register.
  logic               o_v_r;
  logic               o_valid_r;
  logic [BYTE_W-1:0]  o_byte_r;
  logic [IDX_W-1:0]   o_next_r;
  logic [PEND_W-1:0]  o_pend_r;
  logic               o_closed_r;

  // Clearing pass.
  logic               clr_busy_r;
  logic [SW-1:0]      clr_addr_r;

  logic               s1_adv, in_fire;
  logic [BYTE_W:0]    mem_word;
  logic               slot_valid;
  logic               is_data, is_end, is_drain;
  logic               drain_ok, store, new_mark;
  logic               mem_we;
  logic [SW-1:0]      wr_addr, rd_addr;
  logic [BYTE_W:0]    wr_word;
  logic               hit_base, hit_adv, rd_hit;
  logic [SW-1:0]      slot_base, slot_adv;

  // --------------------------------------------------------------------------
  // Decide stage: act on the registered item and the slot word read for it
  // --------------------------------------------------------------------------
  assign s1_adv     = s1_v_r && (!o_v_r || out_chan.ready);
  assign mem_word   = fwd_v_r ? fwd_word_r : rd_word_r;
  assign slot_valid = mem_word[BYTE_W];
  assign is_data    = (s1_cmd_r == CMD_DATA);
  assign is_end     = (s1_cmd_r == CMD_END);
  assign is_drain   = (s1_cmd_r == CMD_DRAIN);
  assign drain_ok   = s1_adv && is_drain && slot_valid;
  assign store      = s1_adv && is_data && s1_hit_r;
  assign new_mark   = store && !slot_valid;

  // Head slot follows next_expected; wrap it to zero with the 64-bit index.
  assign ne_plus = ne_r + IDX_W'(1);
  assign hs_plus = ((hs_r == SW'(CAPACITY - 1)) || (ne_r == '1)) ? '0 : hs_r + SW'(1);
  assign ne_nxt  = drain_ok ? ne_plus : ne_r;
  assign hs_nxt  = drain_ok ? hs_plus : hs_r;

  always_comb begin
    end_pos_nxt   = end_pos_r;
    end_known_nxt = end_known_r;
    if (s1_adv && is_data && s1_fin_r) begin
      // Record the end even when the byte itself falls outside the window.
      end_pos_nxt   = s1_idx_r + IDX_W'(1);
      end_known_nxt = 1'b1;
    end else if (s1_adv && is_end) begin
      end_pos_nxt   = s1_idx_r;
      end_known_nxt = 1'b1;
    end
  end

  assign pend_nxt   = pend_r + PW'(new_mark) - PW'(drain_ok && (pend_r != '0));
  assign closed_nxt = closed_r || (end_known_nxt && (ne_nxt >= end_pos_nxt));

  // Ring write: clearing pass, new byte, or drop the mark of a drained byte.
  assign mem_we  = clr_busy_r || store || drain_ok;
  always_comb begin
    priority if (clr_busy_r) begin
      wr_addr = clr_addr_r;
      wr_word = '0;
    end else if (store) begin
      wr_addr = s1_slot_r;
      wr_word = {1'b1, s1_byte_r};
    end else begin
      wr_addr = hs_r;
      wr_word = {1'b0, mem_word[BYTE_W-1:0]};
    end
  end

  // --------------------------------------------------------------------------
  // Entry stage: window check and slot read against the state the item
  // will see in the decide stage
  // --------------------------------------------------------------------------
  assign in_chan.ready = !clr_busy_r && (!s1_v_r || s1_adv);
  assign in_fire       = in_chan.valid && in_chan.ready;

  bsr_window #(.CAPACITY(CAPACITY)) u_win_base (
    .base_idx  (ne_r),
    .base_slot (hs_r),
    .idx       (in_chan.stream_index),
    .avail     (in_chan.avail_capacity),
    .hit       (hit_base),
    .slot      (slot_base)
  );

  bsr_window #(.CAPACITY(CAPACITY)) u_win_adv (
    .base_idx  (ne_plus),
    .base_slot (hs_plus),
    .idx       (in_chan.stream_index),
    .avail     (in_chan.avail_capacity),
    .hit       (hit_adv),
    .slot      (slot_adv)
  );

  always_comb begin
    rd_hit = drain_ok ? hit_adv : hit_base;
    if (in_chan.cmd == CMD_DRAIN) begin
      rd_addr = hs_nxt;
    end else begin
      rd_addr = drain_ok ? slot_adv : slot_base;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_word_r  <= ring_mem[rd_addr];
      fwd_v_r    <= mem_we && (wr_addr == rd_addr);
      fwd_word_r <= wr_word;
      s1_cmd_r   <= in_chan.cmd;
      s1_idx_r   <= in_chan.stream_index;
      s1_byte_r  <= in_chan.data_byte;
      s1_fin_r   <= in_chan.is_final_byte;
      s1_hit_r   <= rd_hit;
      s1_slot_r  <= rd_addr;
    end
  end

  // --------------------------------------------------------------------------
  // Control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      o_v_r       <= 1'b0;
      ne_r        <= '0;
      hs_r        <= '0;
      end_pos_r   <= '0;
      end_known_r <= 1'b0;
      pend_r      <= '0;
      closed_r    <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
    end else begin
      // Hold the decide stage while the result register is full and not taken.
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end

      if (s1_adv) begin
        o_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        o_v_r <= 1'b0;
      end

      ne_r        <= ne_nxt;
      hs_r        <= hs_nxt;
      end_pos_r   <= end_pos_nxt;
      end_known_r <= end_known_nxt;
      pend_r      <= pend_nxt;
      closed_r    <= closed_nxt;

      // Advance the clearing sweep one slot a cycle.
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + SW'(1);
        if (clr_addr_r == SW'(CAPACITY - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_valid_r  <= drain_ok;
      o_byte_r   <= drain_ok ? mem_word[BYTE_W-1:0] : '0;
      o_next_r   <= ne_nxt;
      o_pend_r   <= pend_nxt[PEND_W-1:0];
      o_closed_r <= closed_nxt;
    end
  end

  assign out_chan.valid         = o_v_r;
  assign out_chan.out_valid     = o_valid_r;
  assign out_chan.out_byte      = o_byte_r;
  assign out_chan.next_index    = o_next_r;
  assign out_chan.pending_count = o_pend_r;
  assign out_chan.stream_closed = o_closed_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_chan.ready)
    else $error("input accepted during the clearing pass");

  a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PW'(CAPACITY))
    else $error("pending count above ring capacity");

  a_empty_result_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && !o_valid_r) |-> (o_byte_r == '0))
    else $error("empty result carries a nonzero byte");

  a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_idx_r) && $stable(ne_r)))
    else $error("decide stage lost its item during a stall");

endmodule
